>>> src/fsmc_pkg.sv
`timescale 1ns / 1ps

package fsmc_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_BYTE_COUNT       = 3'd0;
	localparam logic [2:0] CFG_FRAME_WIDTH      = 3'd1;
	localparam logic [2:0] CFG_FRAME_HEIGHT     = 3'd2;
	localparam logic [2:0] CFG_CHANNEL_COUNT    = 3'd3;
	localparam logic [2:0] CFG_CONFIDENCE_FLOOR = 3'd4;

	// modality classes
	localparam logic [2:0] CLS_CT       = 3'd0;
	localparam logic [2:0] CLS_MR       = 3'd1;
	localparam logic [2:0] CLS_DX       = 3'd2;
	localparam logic [2:0] CLS_US       = 3'd3;
	localparam logic [2:0] CLS_ES       = 3'd4;
	localparam logic [2:0] CLS_SM       = 3'd5;
	localparam logic [2:0] CLS_SURGICAL = 3'd6;

	// confidence levels in hundredths
	localparam logic [6:0] CONF_HIGH = 7'd76;
	localparam logic [6:0] CONF_MID  = 7'd68;
	localparam logic [6:0] CONF_LOW  = 7'd62;

	// decision thresholds
	localparam logic [12:0] K_CT_VAR   = 13'd4800;
	localparam logic [12:0] K_CT_MEAN  = 13'd120;
	localparam logic [12:0] K_DX_VAR   = 13'd2400;
	localparam logic [12:0] K_US_MEAN  = 13'd175;
	localparam logic [12:0] K_US_VAR   = 13'd900;
	localparam logic [12:0] K_HI_VAR   = 13'd4500;
	localparam logic [12:0] K_LO_VAR   = 13'd500;
	localparam logic [12:0] K_SAT_HI   = 13'd32;
	localparam logic [12:0] K_SAT_LO   = 13'd18;
	localparam logic [23:0] LARGE_PIXELS = 24'(3840 * 2160);

	localparam logic [2:0] COLOR_MIN_CHANNELS = 3'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQ,
		ST_SP,
		ST_SPW,
		ST_DEC_ISSUE,
		ST_DEC_WB,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		DS_N2,
		DS_NQ,
		DS_D,
		DS_CT_VAR,
		DS_CT_MEAN,
		DS_DX_VAR,
		DS_US_MEAN,
		DS_US_VAR,
		DS_HI_VAR,
		DS_LO_VAR,
		DS_SAT_HI,
		DS_SAT_LO,
		DS_LARGE
	} dec_step_t;

	typedef struct packed {
		logic ct_var;
		logic ct_mean;
		logic dx_var;
		logic us_mean;
		logic us_var;
		logic hi_var;
		logic lo_var;
		logic sat_hi;
		logic sat_lo;
		logic big_frame;
	} flags_t;

	function automatic logic [7:0] rgb_spread(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (g < lo) lo = g;
		if (b > hi) hi = b;
		if (b < lo) lo = b;
		return hi - lo;
	endfunction

endpackage

>>> src/frame_stats_modality_classifier.sv
`timescale 1ns / 1ps
// each byte: accepted while idle, then square and spread accumulation
// through the shared multiply-accumulate unit; no new byte is taken until that is through
// last byte of a frame: decision steps on the same unit follow, then done
// writes of channel_count of three or more run the divider
// reset clears the frame counters and accumulators and loads register defaults; results cannot be stalled

module frame_stats_modality_classifier
	import fsmc_pkg::*;
#(
	parameter int SAMPLE_TARGET = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  pixel_byte,
	output logic        done,
	output logic [2:0]  modality_class,
	output logic [6:0]  confidence,
	output logic [13:0] samples_taken,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_data
);

	localparam int N_W    = $clog2(2 * SAMPLE_TARGET) + 1;
	localparam int S_W    = N_W + 8;
	localparam int Q_W    = N_W + 16;
	localparam int A_W    = 2 * N_W;
	localparam int B_W    = N_W + 16;
	localparam int ACC_W  = 2 * N_W + 18;
	localparam int STEP_W = 32 - $clog2(SAMPLE_TARGET);
	localparam int DVS_W  = 3;
	localparam int REC_SH = 31 + $clog2(SAMPLE_TARGET);
	localparam logic [31:0] REC_M =
		32'(((64'd1 << REC_SH) + 64'(SAMPLE_TARGET - 1)) / 64'(SAMPLE_TARGET));

	state_t state_q, state_d;

	logic [30:0] byte_count_q;
	logic [14:0] frame_width_q;
	logic [14:0] frame_height_q;
	logic [2:0]  channel_count_q;
	logic [6:0]  confidence_floor_q;

	logic [30:0]       pos_q;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] phase_q;
	logic [N_W-1:0]    n_q;
	logic [S_W-1:0]    s_q;
	logic [Q_W-1:0]    q_q;
	logic [S_W-1:0]    sp_q;
	logic [7:0]        rgb_q [3];
	logic [1:0]        pend_q;
	logic [2:0]        off_q;
	logic [7:0]        v_q;
	logic              sampled_q;
	logic [1:0]        mult_q;
	logic              end_q;
	dec_step_t         dec_step_q;
	logic [A_W-1:0]    n2_q;
	logic signed [ACC_W-1:0] d_q;
	flags_t            flags_q;

	logic                    mac_en;
	logic [A_W-1:0]          mac_a;
	logic [B_W-1:0]          mac_b;
	logic signed [ACC_W-1:0] mac_c;
	logic                    mac_sub;
	logic signed [ACC_W-1:0] acc;

	logic              div_start;
	logic [30:0]       div_dvd;
	logic [DVS_W-1:0]  div_dvs;
	logic              div_done;
	logic [DVS_W-1:0]  remainder;

	logic              cfg_fire;
	logic              needs_div;
	logic              accept;
	logic [30:0]       count_eff;
	logic [30:0]       cfg_count;
	logic [62:0]       step_prod;
	logic [STEP_W-1:0] step_new;
	logic [STEP_W-1:0] ph;
	logic              sampled;
	logic [STEP_W:0]   ph_inc;
	logic              is_color;
	logic [1:0]        pend_new;
	logic [3:0]        off_inc;
	logic              acc_pos;
	logic              acc_neg;
	logic [2:0]        cls;
	logic [6:0]        conf_raw;
	logic [31:0]       n_wide;

	fsmc_mac #(
		.A_W  (A_W),
		.B_W  (B_W),
		.ACC_W(ACC_W)
	) u_mac (
		.clk(clk),
		.en (mac_en),
		.a  (mac_a),
		.b  (mac_b),
		.c  (mac_c),
		.sub(mac_sub),
		.acc(acc)
	);

	fsmc_div #(
		.DVD_W(31),
		.DVS_W(DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.remainder(remainder)
	);

	assign cfg_fire  = cfg_valid && cfg_ready;
	assign needs_div = (cfg_index == CFG_CHANNEL_COUNT) &&
		(cfg_data[2:0] >= COLOR_MIN_CHANNELS);
	assign accept    = start && !busy;

	// sampling step by reciprocal multiplication
	assign cfg_count = (cfg_data == '0) ? 31'd1 : cfg_data;
	assign step_prod = 63'(cfg_count) * 63'(REC_M);
	assign step_new  = step_prod[62:REC_SH];

	assign count_eff = (byte_count_q == '0) ? 31'd1 : byte_count_q;
	assign ph        = (phase_q >= step_q) ? '0 : phase_q;
	assign sampled   = (ph == '0);
	assign ph_inc    = {1'b0, ph} + (STEP_W + 1)'(1);
	assign is_color  = channel_count_q >= COLOR_MIN_CHANNELS;
	assign pend_new  = ((off_q == 3'd0) ? 2'd0 : pend_q) + {1'b0, sampled};
	assign off_inc   = {1'b0, off_q} + 4'd1;
	assign acc_pos   = !acc[ACC_W-1] && (acc != '0);
	assign acc_neg   = acc[ACC_W-1];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cfg_fire && needs_div) state_d = ST_DIV;
				else if (start) state_d = ST_SQ;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_IDLE;
			end
			ST_SQ:        state_d = ST_SP;
			ST_SP:        state_d = ST_SPW;
			ST_SPW:       state_d = end_q ? ST_DEC_ISSUE : ST_IDLE;
			ST_DEC_ISSUE: state_d = ST_DEC_WB;
			ST_DEC_WB:    state_d = (dec_step_q == DS_LARGE) ? ST_DONE : ST_DEC_ISSUE;
			ST_DONE:      state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// outputs and unit operands
	always_comb begin
		busy      = state_q != ST_IDLE;
		cfg_ready = (state_q == ST_IDLE) && !start;
		done      = state_q == ST_DONE;
		div_start = cfg_fire && needs_div;
		div_dvd   = pos_q;
		div_dvs   = cfg_data[2:0];
		mac_en    = 1'b0;
		mac_a     = '0;
		mac_b     = '0;
		mac_c     = '0;
		mac_sub   = 1'b0;
		case (state_q)
			ST_SQ: begin
				mac_en = 1'b1;
				mac_a  = A_W'(v_q);
				mac_b  = sampled_q ? B_W'(v_q) : '0;
				mac_c  = ACC_W'(q_q);
			end
			ST_SP: begin
				mac_en = 1'b1;
				mac_a  = A_W'(rgb_spread(rgb_q[0], rgb_q[1], rgb_q[2]));
				mac_b  = B_W'(mult_q);
				mac_c  = ACC_W'(sp_q);
			end
			ST_DEC_ISSUE: begin
				mac_en  = 1'b1;
				mac_sub = 1'b1;
				case (dec_step_q)
					DS_N2: begin
						mac_a = A_W'(n_q); mac_b = B_W'(n_q); mac_sub = 1'b0;
					end
					DS_NQ: begin
						mac_a = A_W'(n_q); mac_b = B_W'(q_q); mac_sub = 1'b0;
					end
					DS_D: begin
						mac_a = A_W'(s_q); mac_b = B_W'(s_q); mac_c = d_q;
					end
					DS_CT_VAR: begin
						mac_a = n2_q; mac_b = B_W'(K_CT_VAR); mac_c = d_q;
					end
					DS_CT_MEAN: begin
						mac_a = A_W'(n_q); mac_b = B_W'(K_CT_MEAN); mac_c = ACC_W'(s_q);
					end
					DS_DX_VAR: begin
						mac_a = n2_q; mac_b = B_W'(K_DX_VAR); mac_c = d_q;
					end
					DS_US_MEAN: begin
						mac_a = A_W'(n_q); mac_b = B_W'(K_US_MEAN); mac_c = ACC_W'(s_q);
					end
					DS_US_VAR: begin
						mac_a = n2_q; mac_b = B_W'(K_US_VAR); mac_c = d_q;
					end
					DS_HI_VAR: begin
						mac_a = n2_q; mac_b = B_W'(K_HI_VAR); mac_c = d_q;
					end
					DS_LO_VAR: begin
						mac_a = n2_q; mac_b = B_W'(K_LO_VAR); mac_c = d_q;
					end
					DS_SAT_HI: begin
						mac_a = A_W'(n_q); mac_b = B_W'(K_SAT_HI); mac_c = ACC_W'(sp_q);
					end
					DS_SAT_LO: begin
						mac_a = A_W'(n_q); mac_b = B_W'(K_SAT_LO); mac_c = ACC_W'(sp_q);
					end
					DS_LARGE: begin
						mac_a = A_W'(frame_width_q);
						mac_b = B_W'(frame_height_q);
						mac_c = ACC_W'(LARGE_PIXELS);
					end
					default: begin
						mac_en = 1'b0;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_IDLE;
			byte_count_q       <= 31'd1;
			frame_width_q      <= 15'd1;
			frame_height_q     <= 15'd1;
			channel_count_q    <= 3'd1;
			confidence_floor_q <= 7'd10;
			pos_q              <= '0;
			step_q             <= STEP_W'(1);
			phase_q            <= '0;
			n_q                <= '0;
			s_q                <= '0;
			q_q                <= '0;
			sp_q               <= '0;
			rgb_q              <= '{default: 8'd0};
			pend_q             <= '0;
			off_q              <= '0;
			end_q              <= 1'b0;
			dec_step_q         <= DS_N2;
		end else begin
			state_q <= state_d;

			if (cfg_fire) begin
				case (cfg_index)
					CFG_BYTE_COUNT: begin
						byte_count_q <= cfg_data;
						step_q       <= (step_new == '0) ? STEP_W'(1) : step_new;
					end
					CFG_FRAME_WIDTH:      frame_width_q      <= cfg_data[14:0];
					CFG_FRAME_HEIGHT:     frame_height_q     <= cfg_data[14:0];
					CFG_CHANNEL_COUNT:    channel_count_q    <= cfg_data[2:0];
					CFG_CONFIDENCE_FLOOR: confidence_floor_q <= cfg_data[6:0];
					default: begin
					end
				endcase
			end

			if (state_q == ST_DIV && div_done) begin
				off_q <= remainder;
			end

			if (accept) begin
				phase_q <= (ph_inc >= {1'b0, step_q}) ? '0 : ph_inc[STEP_W-1:0];
				if (sampled) begin
					n_q <= n_q + N_W'(1);
					s_q <= s_q + S_W'(pixel_byte);
				end
				pos_q <= pos_q + 31'd1;
				end_q <= (32'(pos_q) + 32'd1) >= 32'(count_eff);
				if (is_color) begin
					off_q <= (off_inc >= {1'b0, channel_count_q}) ? 3'd0 : off_inc[2:0];
					if (off_q < 3'd3) begin
						rgb_q[off_q[1:0]] <= pixel_byte;
						pend_q <= (off_q == 3'd2) ? 2'd0 : pend_new;
					end
				end
			end

			if (state_q == ST_SP) q_q <= acc[Q_W-1:0];
			if (state_q == ST_SPW) begin
				sp_q       <= acc[S_W-1:0];
				dec_step_q <= DS_N2;
			end
			if (state_q == ST_DEC_WB && dec_step_q != DS_LARGE) begin
				dec_step_q <= dec_step_t'(dec_step_q + 4'd1);
			end

			if (state_q == ST_DONE) begin
				pos_q   <= '0;
				phase_q <= '0;
				n_q     <= '0;
				s_q     <= '0;
				q_q     <= '0;
				sp_q    <= '0;
				rgb_q   <= '{default: 8'd0};
				pend_q  <= '0;
				off_q   <= '0;
				end_q   <= 1'b0;
			end
		end
	end

	// per-transaction payload and decision step results
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q       <= pixel_byte;
			sampled_q <= sampled;
			if (!is_color) mult_q <= 2'd0;
			else if (off_q == 3'd2) mult_q <= pend_new;
			else if (off_q >= 3'd3) mult_q <= {1'b0, sampled};
			else mult_q <= 2'd0;
		end
		if (state_q == ST_DEC_WB) begin
			case (dec_step_q)
				DS_N2:      n2_q              <= acc[A_W-1:0];
				DS_NQ:      d_q               <= acc;
				DS_D:       d_q               <= acc;
				DS_CT_VAR:  flags_q.ct_var    <= acc_pos;
				DS_CT_MEAN: flags_q.ct_mean   <= acc_neg;
				DS_DX_VAR:  flags_q.dx_var    <= acc_pos;
				DS_US_MEAN: flags_q.us_mean   <= acc_pos;
				DS_US_VAR:  flags_q.us_var    <= acc_neg;
				DS_HI_VAR:  flags_q.hi_var    <= acc_pos;
				DS_LO_VAR:  flags_q.lo_var    <= acc_neg;
				DS_SAT_HI:  flags_q.sat_hi    <= acc_pos;
				DS_SAT_LO:  flags_q.sat_lo    <= acc_pos;
				DS_LARGE:   flags_q.big_frame <= acc_neg;
				default: begin
				end
			endcase
		end
	end

	// result decode
	always_comb begin
		if (is_color) begin
			if (flags_q.sat_hi) cls = flags_q.big_frame ? CLS_SM : CLS_ES;
			else if (flags_q.sat_lo) cls = CLS_US;
			else cls = CLS_SURGICAL;
		end else begin
			if (flags_q.ct_var && flags_q.ct_mean) cls = CLS_CT;
			else if (flags_q.dx_var) cls = CLS_DX;
			else if (flags_q.us_mean && flags_q.us_var) cls = CLS_US;
			else cls = CLS_MR;
		end
		if (flags_q.hi_var) conf_raw = CONF_HIGH;
		else if (flags_q.lo_var) conf_raw = CONF_LOW;
		else conf_raw = CONF_MID;
	end

	assign n_wide         = 32'(n_q);
	assign modality_class = cls;
	assign confidence     = (conf_raw < confidence_floor_q) ? confidence_floor_q : conf_raw;
	assign samples_taken  = n_wide[13:0];

endmodule

>>> src/fsmc_mac.sv
`timescale 1ns / 1ps

module fsmc_mac #(
	parameter int A_W   = 28,
	parameter int B_W   = 30,
	parameter int ACC_W = 46
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [A_W-1:0]          a,
	input  logic [B_W-1:0]          b,
	input  logic signed [ACC_W-1:0] c,
	input  logic                    sub,
	output logic signed [ACC_W-1:0] acc
);

	logic [A_W+B_W-1:0]      prod;
	logic signed [ACC_W-1:0] prod_t;
	logic signed [ACC_W-1:0] acc_q;

	assign prod   = A_W'(a) * B_W'(b);
	assign prod_t = $signed(ACC_W'(prod));

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= sub ? (c - prod_t) : (c + prod_t);
		end
	end

	assign acc = acc_q;

endmodule

>>> src/fsmc_div.sv
`timescale 1ns / 1ps

module fsmc_div #(
	parameter int DVD_W = 31,
	parameter int DVS_W = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVS_W-1:0] remainder
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule
